// File: rtl/core/fwsi_pkg.sv
// Shared types and constants of the sorted-insert transaction queue.
`default_nettype none

package fwsi_pkg;

    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int PHASE_W   = 3;
    localparam int TIME_W    = 64;
    localparam int ACTION_W  = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_SORTED = 2'd1,
        ACT_POP    = 2'd2,
        ACT_PEEK   = 2'd3
    } action_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [PHASE_W-1:0]   phase;
        logic [TIME_W-1:0]    tstamp;
    } entry_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic push_en;
        logic sorted;
        logic pop_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/fwsi_if.sv
// Request and response channel interfaces of the sorted-insert transaction queue.
`default_nettype none

interface fwsi_req_if;
    logic                           valid;
    logic                           ready;
    logic [fwsi_pkg::ACTION_W-1:0]  action;
    logic [fwsi_pkg::KEY_W-1:0]     packet_key;
    logic [fwsi_pkg::PAYLOAD_W-1:0] payload_ref;
    logic [fwsi_pkg::PHASE_W-1:0]   phase_code;
    logic [fwsi_pkg::TIME_W-1:0]    time_value;

    modport source (
        output valid, action, packet_key, payload_ref, phase_code, time_value,
        input  ready
    );
    modport sink (
        input  valid, action, packet_key, payload_ref, phase_code, time_value,
        output ready
    );
endinterface

interface fwsi_rsp_if #(
    parameter int QUEUE_DEPTH = 16
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [fwsi_pkg::KEY_W-1:0]     out_key;
    logic [fwsi_pkg::PAYLOAD_W-1:0] out_payload;
    logic [fwsi_pkg::PHASE_W-1:0]   out_phase;
    logic [fwsi_pkg::TIME_W-1:0]    out_time;
    logic [CNT_W-1:0]               fill_count;

    modport source (
        output valid, ok, out_key, out_payload, out_phase, out_time, fill_count,
        input  ready
    );
    modport sink (
        input  valid, ok, out_key, out_payload, out_phase, out_time, fill_count,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/fwsi_cell.sv
// One slot of the queue row: holds an entry and shifts toward or away from the head.
`default_nettype none

module fwsi_cell #(
    parameter int QUEUE_DEPTH = 16,
    parameter int IDX         = 0
) (
    input  wire                          clk,
    input  wire fwsi_pkg::cell_ctrl_t    ctrl,
    input  wire [$clog2(QUEUE_DEPTH+1)-1:0] count,
    input  wire fwsi_pkg::entry_t        new_entry,
    input  wire fwsi_pkg::entry_t        lower,
    input  wire fwsi_pkg::entry_t        upper,
    input  wire                          found_in,
    output logic                         found_out,
    output fwsi_pkg::entry_t             entry
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    fwsi_pkg::entry_t entry_reg;
    fwsi_pkg::entry_t entry_next;
    logic             live;
    logic             at_tail;
    logic             greater;

    assign live    = MY_POS < count;
    assign at_tail = MY_POS == count;
    // This slot is an insertion candidate when it is live and its key is strictly greater.
    assign greater   = ctrl.sorted && live && (entry_reg.key > new_entry.key);
    assign found_out = found_in | greater;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop_en)
        begin
            entry_next = upper;
        end
        else if (ctrl.push_en)
        begin
            // The first greater slot takes the new entry, or the tail slot if none was found;
            // every live slot behind an insertion point moves up by one.
            if (!found_in && (greater || at_tail))
            begin
                entry_next = new_entry;
            end
            else if (found_in && (live || at_tail))
            begin
                entry_next = lower;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/fifo_with_sorted_insert.sv
// Top level of the bounded transaction queue with plain and key-sorted insertion.
//
// Requests arrive on the req channel and each produces exactly one result on the
// rsp channel. A request is one of: push at tail, sorted push (placed before the
// first entry, counted from the head, whose key is strictly greater), pop head,
// or peek head. Pushes into a full queue and pops or peeks of an empty queue
// return ok = 0; entry fields of a result are zero unless a pop or peek hit.
// fill_count gives the number of entries held after the request.
//
// The queue is a row of QUEUE_DEPTH cells ordered from the head at cell 0. A pop
// shifts every cell down by one; a sorted push finds the insertion point through a
// ripple chain across the cells and shifts the live cells behind it up by one, all
// in the cycle the request is accepted. Each transfer on req yields its result in
// the next cycle from an output register, so one request per cycle is sustained;
// req.ready drops only while a result waits and rsp.ready is low. Reset empties the
// queue and clears the pending result; stored entries are not cleared.
`default_nettype none

module fifo_with_sorted_insert #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire          clk,
    input wire          rst_n,
    fwsi_req_if.sink    req,
    fwsi_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    fwsi_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic                 found [QUEUE_DEPTH+1];
    fwsi_pkg::entry_t     new_entry;
    fwsi_pkg::cell_ctrl_t ctrl;
    fwsi_pkg::action_t    action;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 ok_reg;
    logic                 ok_next;
    fwsi_pkg::entry_t     out_entry_reg;
    fwsi_pkg::entry_t     out_entry_next;
    logic [CNT_W-1:0]     fill_reg;

    logic accept;
    logic full;
    logic empty;
    logic is_push;
    logic is_read;
    logic is_pop;
    logic is_sorted;

    assign action    = fwsi_pkg::action_t'(req.action);
    assign new_entry = '{key: req.packet_key, payload: req.payload_ref,
                         phase: req.phase_code, tstamp: req.time_value};

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == FULL_COUNT;
    assign empty     = count_reg == '0;

    always_comb
    begin
        is_push   = 1'b0;
        is_read   = 1'b0;
        is_pop    = 1'b0;
        is_sorted = 1'b0;
        unique case (action)
            fwsi_pkg::ACT_PUSH:
            begin
                is_push = 1'b1;
            end
            fwsi_pkg::ACT_SORTED:
            begin
                is_push   = 1'b1;
                is_sorted = 1'b1;
            end
            fwsi_pkg::ACT_POP:
            begin
                is_read = 1'b1;
                is_pop  = 1'b1;
            end
            fwsi_pkg::ACT_PEEK:
            begin
                is_read = 1'b1;
            end
            default:
            begin
                is_push = 1'b0;
            end
        endcase
    end

    assign ctrl = '{push_en: accept && is_push && !full,
                    sorted:  is_sorted,
                    pop_en:  accept && is_pop && !empty};

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        fwsi_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .IDX         (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .new_entry (new_entry),
            .lower     ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
            .upper     ((i == QUEUE_DEPTH-1) ? cell_entry[i]
                                             : cell_entry[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .entry     (cell_entry[i])
        );
    end

    // The head always sits in cell 0, so a pop or peek reads it before any shift.
    assign ok_next        = accept && ((is_push && !full) || (is_read && !empty));
    assign out_entry_next = (is_read && !empty) ? cell_entry[0] : '0;
    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok_next;
            out_entry_reg <= out_entry_next;
            fill_reg      <= count_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = ok_reg;
    assign rsp.out_key     = out_entry_reg.key;
    assign rsp.out_payload = out_entry_reg.payload;
    assign rsp.out_phase   = out_entry_reg.phase;
    assign rsp.out_time    = out_entry_reg.tstamp;
    assign rsp.fill_count  = fill_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds queue depth");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_pop && !empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("successful pop did not remove one entry");

    a_full_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_push && full) |=> (count_reg == FULL_COUNT))
        else $error("push into a full queue changed the count");

    a_insert_point_live: assert property (@(posedge clk) disable iff (!rst_n)
        found[QUEUE_DEPTH] |-> !empty)
        else $error("sorted insertion point found in an empty queue");
`endif

endmodule

`default_nettype wire
